// File: hdl/orw_pkg.sv
// ----------------------------------------------------------------------------
// orw_pkg
// Shared location codes, error codes and the command and status words that
// pass between the operand unit controller and its datapath.
// ----------------------------------------------------------------------------
package orw_pkg;

	localparam logic [3:0] LOC_AL      = 4'd0;
	localparam logic [3:0] LOC_CH      = 4'd5;
	localparam logic [3:0] LOC_AX      = 4'd6;
	localparam logic [3:0] LOC_BX      = 4'd7;
	localparam logic [3:0] LOC_CX      = 4'd8;
	localparam logic [3:0] LOC_IP      = 4'd9;
	localparam logic [3:0] LOC_VIA_A   = 4'd10;
	localparam logic [3:0] LOC_VIA_B   = 4'd11;
	localparam logic [3:0] LOC_VIA_C   = 4'd12;
	localparam logic [3:0] LOC_IMM     = 4'd13;
	localparam logic [3:0] LOC_VIA_IMM = 4'd14;
	localparam logic [3:0] LOC_NONE    = 4'd15;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_LOCATION = 2'd1;
	localparam logic [1:0] ERR_IP_WRITE = 2'd2;

	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_B = 2'd1;

	// Controller to datapath.
	typedef struct packed {
		logic load_in;     // capture the input word
		logic ptr_load;    // pointer from a register or the immediate address
		logic ptr_ind;     // pointer from the two bytes just fetched
		logic q_load;      // register the quotient of the pointer by the memory size
		logic acc_first;   // first memory access of a phase
		logic acc_second;  // second memory access of a phase
		logic ind;         // the accesses fetch the pointer, not the operand
		logic out_load;    // load the result register and commit register writes
	} orw_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_err;
		logic is_reg;
		logic is_ind;
		logic single_rd;
		logic single_wr;
	} orw_status_t;

endpackage

// File: hdl/orw_ctrl.sv
// ----------------------------------------------------------------------------
// orw_ctrl
// Sequencer of the operand unit: walks each word through decode and, where
// needed, address reduction, pointer fetch and data access; owns out_valid.
// ----------------------------------------------------------------------------
module orw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  orw_pkg::orw_status_t status,
	output orw_pkg::orw_cmd_t    cmd
);
	import orw_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_RED    = 4'd2;
	localparam logic [3:0] S_IND0   = 4'd3;
	localparam logic [3:0] S_IND1   = 4'd4;
	localparam logic [3:0] S_IND2   = 4'd5;
	localparam logic [3:0] S_MEM0   = 4'd6;
	localparam logic [3:0] S_MEM1   = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       ind_done_q;
	logic       out_valid_q;
	logic       fin_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.is_err || status.is_reg) begin
					state_d = S_FIN;
				end else begin
					cmd.ptr_load = 1'b1;
					state_d      = S_RED;
				end
			end
			S_RED: begin
				cmd.q_load = 1'b1;
				state_d    = (status.is_ind && !ind_done_q) ? S_IND0 : S_MEM0;
			end
			S_IND0: begin
				cmd.ind       = 1'b1;
				cmd.acc_first = 1'b1;
				state_d       = S_IND1;
			end
			S_IND1: begin
				cmd.ind        = 1'b1;
				cmd.acc_second = 1'b1;
				state_d        = S_IND2;
			end
			S_IND2: begin
				cmd.ptr_ind = 1'b1;
				state_d     = S_RED;
			end
			S_MEM0: begin
				cmd.acc_first = 1'b1;
				state_d = (status.single_rd || status.single_wr) ? S_FIN : S_MEM1;
			end
			S_MEM1: begin
				cmd.acc_second = 1'b1;
				state_d        = S_FIN;
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ind_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in) begin
				ind_done_q <= 1'b0;
			end else if (cmd.ptr_ind) begin
				ind_done_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/orw_dp.sv
// ----------------------------------------------------------------------------
// orw_dp
// Datapath of the operand unit: input word registers, the A, B and C
// registers, the pointer with its modulo reduction, the byte memory and the
// result register.
// ----------------------------------------------------------------------------
module orw_dp #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  orw_pkg::orw_cmd_t    cmd,
	output orw_pkg::orw_status_t status,
	input  logic                 opcode,
	input  logic [3:0]           location,
	input  logic                 relative,
	input  logic [7:0]           instr_size,
	input  logic [15:0]          imm_addr,
	input  logic [15:0]          instr_pointer,
	input  logic [15:0]          write_data,
	input  logic                 narrow,
	output logic [15:0]          read_data,
	output logic                 sign_bit,
	output logic                 is_byte,
	output logic                 is_memory,
	output logic [1:0]           error_code
);
	import orw_pkg::*;

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	// Rounded-up reciprocal, exact for every 16-bit dividend at these sizes.
	localparam longint RECIP_L = ((64'd1 << 32) + MEM_BYTES - 1) / MEM_BYTES;
	localparam int RW = 34 - $clog2(MEM_BYTES);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam logic [15:0] LAST_IDX = 16'(MEM_BYTES - 1);

	// Captured input word.
	logic        op_q;
	logic [3:0]  loc_q;
	logic        rel_q;
	logic [7:0]  isz_q;
	logic [15:0] imm_q;
	logic [15:0] ip_q;
	logic [15:0] wd_q;
	logic        nar_q;

	logic [15:0] reg_a_q;
	logic [15:0] reg_b_q;
	logic [15:0] reg_c_q;

	logic [15:0] ptr_q;
	logic [15:0] quo_q;
	logic [7:0]  hi_q;
	logic [7:0]  rd_q;
	logic [7:0]  mem [MEM_BYTES];

	logic [15:0] res_data_q;
	logic        res_sign_q;
	logic        res_byte_q;
	logic        res_mem_q;
	logic [1:0]  res_err_q;

	logic        is_write;
	logic [15:0] offset;
	logic [15:0] ptr_base;
	logic [47:0] quo_prod;
	logic [31:0] quo_back;
	logic [15:0] rem;
	logic [AW-1:0] idx0;
	logic [AW-1:0] idx1;
	logic        mem_acc;
	logic        mem_re;
	logic        mem_we;
	logic        use_idx1;
	logic [AW-1:0] mem_addr;
	logic [7:0]  mem_wdat;

	logic [1:0]  reg_idx;
	logic [15:0] reg_cur;
	logic        reg_we;
	logic [15:0] reg_new;
	logic [15:0] res_data;
	logic        res_sign;
	logic        res_byte;
	logic        res_mem;
	logic [1:0]  res_err;

	assign is_write = (op_q == OP_WRITE);

	assign status.is_err    = (loc_q == LOC_NONE) || ((loc_q == LOC_IP) && is_write);
	assign status.is_reg    = (loc_q <= LOC_IP);
	assign status.is_ind    = (loc_q == LOC_VIA_IMM);
	assign status.single_rd = !is_write && nar_q;
	assign status.single_wr = is_write && nar_q && (loc_q != LOC_IMM);

	assign offset = rel_q ? (ip_q + {8'd0, isz_q}) : 16'd0;

	always_comb begin
		unique case (loc_q)
			LOC_VIA_A: ptr_base = reg_a_q;
			LOC_VIA_B: ptr_base = reg_b_q;
			default:   ptr_base = reg_c_q;
		endcase
	end

	// Address reduction: quotient registered, remainder formed at the access.
	assign quo_prod = 48'(ptr_q) * 48'(RECIP);
	assign quo_back = 32'(quo_q) * 32'(MEM_BYTES);
	assign rem      = 16'(32'(ptr_q) - quo_back);
	assign idx0     = AW'(rem);
	assign idx1     = ((ptr_q == 16'hFFFF) || (rem == LAST_IDX)) ? '0 : AW'(rem + 16'd1);

	assign mem_acc = cmd.acc_first || cmd.acc_second;
	assign mem_re  = mem_acc && (cmd.ind || !is_write);
	assign mem_we  = mem_acc && !cmd.ind && is_write;

	always_comb begin
		if (cmd.acc_second) begin
			use_idx1 = cmd.ind || !is_write;
		end else if (cmd.ind) begin
			use_idx1 = 1'b0;
		end else if (is_write) begin
			use_idx1 = !status.single_wr;
		end else begin
			// A narrow read of an immediate takes only its low byte.
			use_idx1 = nar_q && (loc_q == LOC_IMM);
		end
	end

	assign mem_addr = use_idx1 ? idx1 : idx0;
	assign mem_wdat = cmd.acc_second ? wd_q[15:8] : wd_q[7:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdat;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= opcode;
			loc_q <= location;
			rel_q <= relative;
			isz_q <= instr_size;
			imm_q <= imm_addr;
			ip_q  <= instr_pointer;
			wd_q  <= write_data;
			nar_q <= narrow;
		end
		if (cmd.ptr_load) begin
			if ((loc_q == LOC_IMM) || (loc_q == LOC_VIA_IMM)) begin
				ptr_q <= imm_q;
			end else begin
				ptr_q <= ptr_base + offset;
			end
		end else if (cmd.ptr_ind) begin
			ptr_q <= {hi_q, rd_q} + offset;
		end
		if (cmd.q_load) begin
			quo_q <= quo_prod[47:32];
		end
		if (cmd.acc_second && mem_re) begin
			hi_q <= rd_q;
		end
		if (cmd.out_load) begin
			res_data_q <= res_data;
			res_sign_q <= res_sign;
			res_byte_q <= res_byte;
			res_mem_q  <= res_mem;
			res_err_q  <= res_err;
		end
	end

	// Result and register update for the word in hand.
	always_comb begin
		reg_idx  = (loc_q <= LOC_CH) ? loc_q[2:1] : 2'(loc_q - LOC_AX);
		unique case (reg_idx)
			REG_A:   reg_cur = reg_a_q;
			REG_B:   reg_cur = reg_b_q;
			default: reg_cur = reg_c_q;
		endcase
		if (loc_q == LOC_IP) begin
			reg_cur = ip_q;
		end
		reg_we   = 1'b0;
		reg_new  = reg_cur;
		res_data = 16'd0;
		res_sign = 1'b0;
		res_byte = 1'b0;
		res_mem  = 1'b0;
		res_err  = ERR_NONE;
		if (loc_q == LOC_NONE) begin
			res_err = ERR_LOCATION;
		end else if ((loc_q == LOC_IP) && is_write) begin
			res_err = ERR_IP_WRITE;
		end else if (loc_q <= LOC_CH) begin
			res_byte = 1'b1;
			if (is_write) begin
				reg_we   = 1'b1;
				res_sign = wd_q[7];
				if (loc_q[0]) begin
					res_data = {wd_q[7:0], 8'd0};
					reg_new  = {wd_q[7:0], reg_cur[7:0]};
				end else begin
					res_data = {8'd0, wd_q[7:0]};
					reg_new  = {reg_cur[15:8], wd_q[7:0]};
				end
			end else if (loc_q[0]) begin
				res_data = {8'd0, reg_cur[15:8]};
				res_sign = reg_cur[15];
			end else begin
				res_data = {8'd0, reg_cur[7:0]};
				res_sign = reg_cur[7];
			end
		end else if (loc_q <= LOC_IP) begin
			if (is_write) begin
				reg_we   = 1'b1;
				reg_new  = wd_q;
				res_data = wd_q;
				res_sign = nar_q ? wd_q[7] : wd_q[15];
			end else begin
				res_data = nar_q ? {8'd0, reg_cur[7:0]} : reg_cur;
				res_sign = nar_q ? reg_cur[7] : reg_cur[15];
			end
		end else begin
			res_mem  = 1'b1;
			res_byte = (loc_q != LOC_IMM);
			if (is_write) begin
				res_data = status.single_wr ? {8'd0, wd_q[7:0]} : wd_q;
				res_sign = nar_q ? wd_q[7] : wd_q[15];
			end else begin
				res_data = nar_q ? {8'd0, rd_q} : {hi_q, rd_q};
				res_sign = nar_q ? rd_q[7] : hi_q[7];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q <= 16'd0;
			reg_b_q <= 16'd0;
			reg_c_q <= 16'd0;
		end else if (cmd.out_load && reg_we) begin
			unique case (reg_idx)
				REG_A:   reg_a_q <= reg_new;
				REG_B:   reg_b_q <= reg_new;
				default: reg_c_q <= reg_new;
			endcase
		end
	end

	assign read_data  = res_data_q;
	assign sign_bit   = res_sign_q;
	assign is_byte    = res_byte_q;
	assign is_memory  = res_mem_q;
	assign error_code = res_err_q;

endmodule

// File: hdl/operand_resolve_read_write_core.sv
// ----------------------------------------------------------------------------
// operand_resolve_read_write_core
// Operand unit of a 16-bit virtual machine: resolves a location code and
// reads or writes the A, B, C registers or a big-endian byte memory.
// ----------------------------------------------------------------------------
// One word is in flight at a time; in_ready is high only while the unit is
// idle. A register or an error goes from decode straight to the result; a
// memory operand has its pointer reduced modulo MEM_BYTES, then one access
// per byte, and a pointer held at the immediate is first fetched in two
// byte accesses and then reduced in turn. The single-port byte memory gives
// one byte per cycle with registered read data. The memory is not cleared
// at reset; the result register lets the next word be accepted while a
// result waits.
module operand_resolve_read_write_core #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [3:0]  location,
	input  logic        relative,
	input  logic [7:0]  instr_size,
	input  logic [15:0] imm_addr,
	input  logic [15:0] instr_pointer,
	input  logic [15:0] write_data,
	input  logic        narrow,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic        sign_bit,
	output logic        is_byte,
	output logic        is_memory,
	output logic [1:0]  error_code
);
	import orw_pkg::*;

	orw_cmd_t    cmd;
	orw_status_t status;

	orw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	orw_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.opcode        (opcode),
		.location      (location),
		.relative      (relative),
		.instr_size    (instr_size),
		.imm_addr      (imm_addr),
		.instr_pointer (instr_pointer),
		.write_data    (write_data),
		.narrow        (narrow),
		.read_data     (read_data),
		.sign_bit      (sign_bit),
		.is_byte       (is_byte),
		.is_memory     (is_memory),
		.error_code    (error_code)
	);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the operand unit against a predictor of its register file and byte
// memory. Directed words cover registers, error codes and memory operands.
// Random words then follow, with and without idling on both handshakes.
// ----------------------------------------------------------------------------
module tb;
	import orw_pkg::*;

	localparam logic [3:0] LOC_AH = 4'd1;
	localparam logic [3:0] LOC_BL = 4'd2;
	localparam logic [3:0] LOC_BH = 4'd3;
	localparam logic [3:0] LOC_CL = 4'd4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		KIND_REG_WORD,
		KIND_REG_LOW,
		KIND_REG_HIGH,
		KIND_MEM_BYTE,
		KIND_MEM_WORD
	} access_kind_t;

	typedef struct packed {
		logic        op;
		logic [3:0]  loc;
		logic        rel;
		logic [7:0]  isz;
		logic [15:0] imm;
		logic [15:0] ip;
		logic [15:0] wdata;
		logic        nar;
	} operand_t;

	typedef struct packed {
		logic [15:0] data;
		logic        sgn;
		logic        byte_op;
		logic        mem_op;
		logic [1:0]  err;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = 1'b0;
	logic [3:0]  location = 4'd0;
	logic        relative = 1'b0;
	logic [7:0]  instr_size = 8'd0;
	logic [15:0] imm_addr = 16'd0;
	logic [15:0] instr_pointer = 16'd0;
	logic [15:0] write_data = 16'd0;
	logic        narrow = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] read_data;
	logic        sign_bit;
	logic        is_byte;
	logic        is_memory;
	logic [1:0]  error_code;

	// Predicted machine state.
	logic [15:0] cpu_regs [0:2];
	logic [7:0]  mem_image [0:65535];
	bit          mem_known [0:65535];

	outcome_t expected_results [$];
	int mismatch_count = 0;
	int stall_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	operand_resolve_read_write_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.location(location),
		.relative(relative),
		.instr_size(instr_size),
		.imm_addr(imm_addr),
		.instr_pointer(instr_pointer),
		.write_data(write_data),
		.narrow(narrow),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.sign_bit(sign_bit),
		.is_byte(is_byte),
		.is_memory(is_memory),
		.error_code(error_code)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic operand_t operand_word(logic op, logic [3:0] loc, logic rel,
			logic [7:0] isz, logic [15:0] imm, logic [15:0] ip, logic [15:0] wdata,
			logic nar);
		operand_t w;
		w.op = op;
		w.loc = loc;
		w.rel = rel;
		w.isz = isz;
		w.imm = imm;
		w.ip = ip;
		w.wdata = wdata;
		w.nar = nar;
		return w;
	endfunction

	function automatic logic [15:0] mem_word(logic [15:0] a);
		return {mem_image[a], mem_image[16'(a + 16'd1)]};
	endfunction

	function automatic bit word_known(logic [15:0] a);
		return mem_known[a] && mem_known[16'(a + 16'd1)];
	endfunction

	// Most pointers land in a small window around address zero so that
	// reads often find bytes that were written before.
	function automatic logic [15:0] near_addr();
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		if ($urandom_range(1))
			return 16'($urandom_range(63));
		return 16'hFFC0 + 16'($urandom_range(63));
	endfunction

	task automatic store_byte(input logic [15:0] a, input logic [7:0] v);
		mem_image[a] = v;
		mem_known[a] = 1'b1;
	endtask

	// Resolves one accepted word, updates the predicted state and queues
	// the result it must produce.
	task automatic resolve_operand(input operand_t w);
		outcome_t r;
		access_kind_t kind;
		logic [15:0] cur;
		logic [15:0] addr;
		logic [15:0] full;
		logic [1:0] sel;
		bit is_ip;
		r = '0;
		kind = KIND_REG_WORD;
		cur = w.ip;
		addr = 16'd0;
		sel = REG_A;
		is_ip = 1'b0;
		if (w.loc == LOC_NONE) begin
			r.err = ERR_LOCATION;
		end else if (w.loc == LOC_IP && w.op == OP_WRITE) begin
			r.err = ERR_IP_WRITE;
		end else begin
			if (w.loc <= LOC_CH) begin
				sel = w.loc[2:1];
				kind = w.loc[0] ? KIND_REG_HIGH : KIND_REG_LOW;
			end else if (w.loc <= LOC_IP) begin
				is_ip = (w.loc == LOC_IP);
				sel = 2'(w.loc - LOC_AX);
				kind = KIND_REG_WORD;
			end else if (w.loc <= LOC_VIA_C) begin
				addr = cpu_regs[2'(w.loc - LOC_VIA_A)];
				if (w.rel)
					addr = 16'(w.ip + {8'h00, w.isz} + addr);
				kind = KIND_MEM_BYTE;
			end else if (w.loc == LOC_IMM) begin
				addr = w.imm;
				kind = KIND_MEM_WORD;
			end else begin
				addr = mem_word(w.imm);
				if (w.rel)
					addr = 16'(w.ip + {8'h00, w.isz} + addr);
				kind = KIND_MEM_BYTE;
			end
			if (kind == KIND_REG_WORD || kind == KIND_REG_LOW || kind == KIND_REG_HIGH)
				cur = is_ip ? w.ip : cpu_regs[sel];

			if (w.op == OP_READ) begin
				case (kind)
					KIND_REG_WORD: r.data = w.nar ? {8'h00, cur[7:0]} : cur;
					KIND_REG_LOW:  r.data = {8'h00, cur[7:0]};
					KIND_REG_HIGH: r.data = {8'h00, cur[15:8]};
					KIND_MEM_BYTE: r.data = w.nar ? {8'h00, mem_image[addr]} : mem_word(addr);
					default: begin
						// A narrow immediate takes only its low byte.
						r.data = w.nar ? {8'h00, mem_image[16'(addr + 16'd1)]} : mem_word(addr);
					end
				endcase
			end else begin
				case (kind)
					KIND_REG_WORD: begin
						cur = w.wdata;
						r.data = w.wdata;
					end
					KIND_REG_LOW: begin
						r.data = {8'h00, w.wdata[7:0]};
						cur = {cur[15:8], w.wdata[7:0]};
					end
					KIND_REG_HIGH: begin
						r.data = {w.wdata[7:0], 8'h00};
						cur = {w.wdata[7:0], cur[7:0]};
					end
					default: begin
						if (kind == KIND_MEM_BYTE && w.nar) begin
							r.data = {8'h00, w.wdata[7:0]};
							store_byte(addr, w.wdata[7:0]);
						end else begin
							r.data = w.wdata;
							store_byte(16'(addr + 16'd1), w.wdata[7:0]);
							store_byte(addr, w.wdata[15:8]);
						end
					end
				endcase
				if (kind == KIND_REG_WORD || kind == KIND_REG_LOW || kind == KIND_REG_HIGH)
					cpu_regs[sel] = cur;
			end

			// The sign is taken from the operand as it stands after the access.
			full = mem_word(addr);
			case (kind)
				KIND_REG_LOW:  r.sgn = cur[7];
				KIND_REG_HIGH: r.sgn = cur[15];
				KIND_MEM_BYTE: r.sgn = full[15];
				KIND_MEM_WORD: r.sgn = w.nar ? full[7] : full[15];
				default:       r.sgn = w.nar ? cur[7] : cur[15];
			endcase
			r.byte_op = (kind == KIND_REG_LOW || kind == KIND_REG_HIGH ||
				kind == KIND_MEM_BYTE);
			r.mem_op = (kind == KIND_MEM_BYTE || kind == KIND_MEM_WORD);
			r.err = ERR_NONE;
		end
		expected_results.push_back(r);
	endtask

	task automatic send_operand(input operand_t w);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = w.op;
		location = w.loc;
		relative = w.rel;
		instr_size = w.isz;
		imm_addr = w.imm;
		instr_pointer = w.ip;
		write_data = w.wdata;
		narrow = w.nar;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		resolve_operand(w);
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		outcome_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with none expected, read_data %h error_code %0d",
				$time, read_data, error_code);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("read_data", want.data, read_data);
			compare_field("sign_bit", 16'(want.sgn), 16'(sign_bit));
			compare_field("is_byte", 16'(want.byte_op), 16'(is_byte));
			compare_field("is_memory", 16'(want.mem_op), 16'(is_memory));
			compare_field("error_code", 16'(want.err), 16'(error_code));
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_result();
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[operand_resolve_read_write_core] ERROR");
				$finish;
			end
		end
	end

	task automatic test_register_access();
		send_operand(operand_word(OP_WRITE, LOC_AX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
		send_operand(operand_word(OP_WRITE, LOC_AL, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h1280, 1'b1));
		send_operand(operand_word(OP_WRITE, LOC_AH, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h007F, 1'b0));
		send_operand(operand_word(OP_READ, LOC_AX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_operand(operand_word(OP_READ, LOC_AX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_WRITE, LOC_BX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h8000, 1'b0));
		send_operand(operand_word(OP_WRITE, LOC_CX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
		send_operand(operand_word(OP_READ, LOC_BH, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_READ, LOC_BL, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_operand(operand_word(OP_READ, LOC_CL, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_READ, LOC_CH, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_READ, LOC_IP, 1'b0, 8'h00, 16'h0000, 16'hFF80, 16'h0000, 1'b1));
	endtask

	task automatic test_error_codes();
		send_operand(operand_word(OP_WRITE, LOC_IP, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_operand(operand_word(OP_READ, LOC_NONE, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_operand(operand_word(OP_WRITE, LOC_NONE, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
	endtask

	task automatic test_memory_access();
		// An immediate at the top of memory wraps to address zero.
		send_operand(operand_word(OP_WRITE, LOC_IMM, 1'b0, 8'h00, 16'hFFFF, 16'h0000, 16'hA55A, 1'b0));
		send_operand(operand_word(OP_READ, LOC_IMM, 1'b0, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_READ, LOC_IMM, 1'b0, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
		send_operand(operand_word(OP_WRITE, LOC_AX, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0010, 1'b0));
		send_operand(operand_word(OP_WRITE, LOC_VIA_A, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h8001, 1'b0));
		send_operand(operand_word(OP_READ, LOC_VIA_A, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_operand(operand_word(OP_WRITE, LOC_VIA_A, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
		// IP plus size plus B wraps back onto the same bytes.
		send_operand(operand_word(OP_READ, LOC_VIA_B, 1'b1, 8'h10, 16'h0000, 16'h8000, 16'h0000, 1'b0));
		send_operand(operand_word(OP_WRITE, LOC_VIA_IMM, 1'b1, 8'hFF, 16'hFFFF, 16'h0000, 16'h1234, 1'b0));
		send_operand(operand_word(OP_READ, LOC_VIA_IMM, 1'b1, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
	endtask

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		operand_t w;
		logic [15:0] base;
		logic [15:0] addr;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int k = 0; k < count; k++) begin
			w.op = 1'($urandom_range(1));
			w.loc = 4'($urandom_range(15));
			w.rel = 1'($urandom_range(1));
			w.isz = 8'($urandom_range(255));
			w.imm = 16'($urandom);
			w.ip = 16'($urandom);
			w.wdata = 16'($urandom);
			w.nar = 1'($urandom_range(1));
			// Register values double as pointers, so keep many of them near zero.
			if ($urandom_range(1))
				w.wdata = near_addr();
			if (w.loc == LOC_IMM) begin
				if ($urandom_range(7) != 0)
					w.imm = near_addr();
				if (w.op == OP_READ && !word_known(w.imm))
					w.op = OP_WRITE;
			end else if (w.loc >= LOC_VIA_A && w.loc != LOC_NONE) begin
				if (w.loc == LOC_VIA_IMM) begin
					if ($urandom_range(7) != 0)
						w.imm = near_addr();
					// Plant the pointer first when nothing is stored there yet.
					if (!word_known(w.imm))
						send_operand(operand_word(OP_WRITE, LOC_IMM, 1'($urandom_range(1)),
							8'($urandom_range(255)), w.imm, 16'($urandom), near_addr(),
							1'($urandom_range(1))));
					base = mem_word(w.imm);
				end else begin
					base = cpu_regs[2'(w.loc - LOC_VIA_A)];
				end
				if (w.rel && $urandom_range(3) != 0)
					w.ip = 16'(near_addr() - {8'h00, w.isz} - base);
				addr = w.rel ? 16'(w.ip + {8'h00, w.isz} + base) : base;
				// Both bytes feed the sign, so a read or a byte write needs them stored.
				if ((w.op == OP_READ || w.nar) && !word_known(addr)) begin
					w.op = OP_WRITE;
					w.nar = 1'b0;
				end
			end
			send_operand(w);
		end
	endtask

	initial begin
		for (int i = 0; i < 3; i++)
			cpu_regs[i] = 16'h0000;
		tx_idle_pct = 25;
		rx_idle_pct = 53;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_error_codes();
		test_memory_access();
		test_random(330, 25, 53);
		test_random(330, 53, 25);
		test_random(340, 0, 0);

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[operand_resolve_read_write_core] OK");
		else
			$display("[operand_resolve_read_write_core] ERROR");
		$finish;
	end

endmodule

// File: files.f
hdl/orw_pkg.sv
hdl/orw_ctrl.sv
hdl/orw_dp.sv
hdl/operand_resolve_read_write_core.sv
tb/tb.sv
